// ===== rtl/core/cbp_pkg.sv =====
// shared types and constants of the code and symbol bit packer
package cbp_pkg;

    // command codes of an input item
    localparam logic CMD_PACK  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // field widths
    localparam int CodeFieldBits = 16;
    localparam int CodeWidthBits = 5;
    localparam int SymbolBits    = 8;
    localparam int ByteBits      = 8;
    localparam int FillBits      = 3;

    // default limit on packed code bits
    localparam int MaxCodeBitsDef = 16;

    // one record carries up to three completed bytes
    localparam int MaxRecBytes = 3;
    localparam int RecBits     = MaxRecBytes * ByteBits;
    localparam int RecCntW     = $clog2(MaxRecBytes + 1);

    // depth of the queue between front and back
    localparam int QueueDepth = 2;

    // completed bytes of one item, earliest byte in the low bits
    typedef struct packed {
        logic [RecBits-1:0] data;
        logic [RecCntW-1:0] nbytes;
    } t_rec;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== rtl/core/code_symbol_bit_packer_unit.sv =====
// top level of the code and symbol bit packer
// path: an accepted item is written into the queue, and its first byte then moves into the
// output register, which drives the outputs
// throughput: an item is accepted every cycle while the queue has room; the output sends
// one byte per cycle while the consumer pops, so a pair yields one to three bytes through
// the single-byte output register, and the front takes new items while earlier bytes are sent
// reset: synchronous active-low reset clears the pending bits, the queue and the output
module code_symbol_bit_packer_unit #(
    parameter int MAX_CODE_BITS = cbp_pkg::MaxCodeBitsDef
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic                              i_cmd,
    input  logic [cbp_pkg::CodeFieldBits-1:0] i_code_value,
    input  logic [cbp_pkg::CodeWidthBits-1:0] i_code_width,
    input  logic [cbp_pkg::SymbolBits-1:0]    i_symbol,
    output logic                              empty,
    input  logic                              pop,
    output logic [cbp_pkg::ByteBits-1:0]      o_out_byte,
    output logic                              o_last
);
    import cbp_pkg::*;

    t_rec      front_rec;
    t_rec      q_head;
    t_q_status q_stat;
    logic      q_push;
    logic      q_pop;

    assign full = q_stat.full;

    // packing front
    cbp_front #(
        .MAX_CODE_BITS(MAX_CODE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_cmd        (i_cmd),
        .i_code_value (i_code_value),
        .i_code_width (i_code_width),
        .i_symbol     (i_symbol),
        .i_q_stat     (q_stat),
        .o_q_push     (q_push),
        .o_rec        (front_rec)
    );

    // record queue
    cbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (front_rec),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    // byte sender
    cbp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (q_head),
        .i_q_stat   (q_stat),
        .i_pop      (pop),
        .o_q_pop    (q_pop),
        .o_empty    (empty),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

`ifndef ASSERT_OFF
    // the front never writes a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("record pushed into full queue");

    // every queued record carries at least one byte
    a_rec_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !q_stat.empty |-> (q_head.nbytes != '0))
        else $error("empty record in queue");

    // the back only retires a record that exists
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("record retired from empty queue");
`endif

endmodule

// ===== rtl/core/cbp_front.sv =====
// front part: accepts items, keeps the partial byte and builds byte records
module cbp_front #(
    parameter int MAX_CODE_BITS = cbp_pkg::MaxCodeBitsDef
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  logic                             i_cmd,
    input  logic [cbp_pkg::CodeFieldBits-1:0] i_code_value,
    input  logic [cbp_pkg::CodeWidthBits-1:0] i_code_width,
    input  logic [cbp_pkg::SymbolBits-1:0]    i_symbol,
    input  cbp_pkg::t_q_status               i_q_stat,
    output logic                             o_q_push,
    output cbp_pkg::t_rec                    o_rec
);
    import cbp_pkg::*;

    // widest code actually packed and the accumulator that holds one item
    localparam int EffMax = (MAX_CODE_BITS < CodeFieldBits) ? MAX_CODE_BITS : CodeFieldBits;
    localparam int AccW   = (1 << FillBits) - 1 + EffMax + SymbolBits;

    logic [ByteBits-1:0]      r_partial;
    logic [ByteBits-1:0]      n_partial;
    logic [FillBits-1:0]      r_fill;
    logic [FillBits-1:0]      n_fill;

    logic                     accept;
    logic [CodeWidthBits-1:0] eff;
    logic [EffMax-1:0]        code_bits;
    logic [CodeWidthBits-1:0] sym_sh;
    logic [CodeWidthBits-1:0] total;
    logic [AccW-1:0]          acc;
    logic [AccW-1:0]          rest;
    logic [RecCntW-1:0]       pk_nbytes;
    logic [FillBits-1:0]      pk_fill;
    logic [ByteBits-1:0]      pk_partial;

    assign accept = i_push && !i_q_stat.full;

    // clamp the code width and mask the code word
    always_comb begin
        if (i_code_width > CodeWidthBits'(EffMax)) begin
            eff = CodeWidthBits'(EffMax);
        end else begin
            eff = i_code_width;
        end
        for (int j = 0; j < EffMax; j++) begin
            code_bits[j] = i_code_value[j] && (CodeWidthBits'(j) < eff);
        end
    end

    // append code and symbol bits behind the pending bits
    always_comb begin
        sym_sh = CodeWidthBits'(r_fill) + eff;
        acc    = AccW'(r_partial) | (AccW'(code_bits) << r_fill)
               | (AccW'(i_symbol) << sym_sh);
        total  = CodeWidthBits'(r_fill) + eff + CodeWidthBits'(SymbolBits);
        pk_nbytes = RecCntW'(total >> FillBits);
        pk_fill   = total[FillBits-1:0];
        rest      = acc >> {pk_nbytes, FillBits'(0)};
        for (int j = 0; j < ByteBits; j++) begin
            pk_partial[j] = rest[j] && (FillBits'(j) < pk_fill);
        end
    end

    // record and next pending state per command
    always_comb begin
        n_partial = r_partial;
        n_fill    = r_fill;
        case (i_cmd)
            CMD_FLUSH: begin
                o_rec.data   = RecBits'(r_partial);
                o_rec.nbytes = (r_fill != '0) ? RecCntW'(1) : '0;
                if (accept) begin
                    n_partial = '0;
                    n_fill    = '0;
                end
            end
            CMD_PACK: begin
                o_rec.data   = RecBits'(acc);
                o_rec.nbytes = pk_nbytes;
                if (accept) begin
                    n_partial = pk_partial;
                    n_fill    = pk_fill;
                end
            end
            default: begin
                o_rec.data   = '0;
                o_rec.nbytes = '0;
            end
        endcase
        o_q_push = accept && (o_rec.nbytes != '0);
    end

    // pending bit state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_fill    <= '0;
        end else begin
            r_partial <= n_partial;
            r_fill    <= n_fill;
        end
    end

endmodule

// ===== rtl/core/cbp_queue.sv =====
// short record queue between front and back
module cbp_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  cbp_pkg::t_rec       i_rec,
    input  logic                i_pop,
    output cbp_pkg::t_rec       o_head,
    output cbp_pkg::t_q_status  o_stat
);
    import cbp_pkg::*;

    localparam int IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW = $clog2(QueueDepth + 1);

    t_rec            r_mem [QueueDepth];
    logic [IdxW-1:0] r_wr_ptr;
    logic [IdxW-1:0] n_wr_ptr;
    logic [IdxW-1:0] r_rd_ptr;
    logic [IdxW-1:0] n_rd_ptr;
    logic [CntW-1:0] r_count;
    logic [CntW-1:0] n_count;
    logic            do_push;
    logic            do_pop;

    assign o_stat.full  = (r_count == CntW'(QueueDepth));
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == IdxW'(QueueDepth - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == IdxW'(QueueDepth - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

endmodule

// ===== rtl/core/cbp_back.sv =====
// back part: sends the bytes of each record one per cycle while the consumer pops, through the output register
module cbp_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cbp_pkg::t_rec                 i_head,
    input  cbp_pkg::t_q_status            i_q_stat,
    input  logic                          i_pop,
    output logic                          o_q_pop,
    output logic                          o_empty,
    output logic [cbp_pkg::ByteBits-1:0]  o_out_byte,
    output logic                          o_last
);
    import cbp_pkg::*;

    logic                r_out_valid;
    logic                n_out_valid;
    logic [ByteBits-1:0] r_out_byte;
    logic                r_last;
    logic [RecCntW-1:0]  r_idx;
    logic [RecCntW-1:0]  n_idx;
    logic                load;
    logic                last_sel;
    logic [ByteBits-1:0] sel_byte;

    assign o_empty    = !r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_last     = r_last;

    // pick the current byte of the head record
    always_comb begin
        case (r_idx)
            RecCntW'(0): sel_byte = i_head.data[0 +: ByteBits];
            RecCntW'(1): sel_byte = i_head.data[ByteBits +: ByteBits];
            RecCntW'(2): sel_byte = i_head.data[2*ByteBits +: ByteBits];
            default:     sel_byte = i_head.data[0 +: ByteBits];
        endcase
    end

    // load the output register whenever a record is queued and the register is free or being taken
    always_comb begin
        load        = !i_q_stat.empty && (!r_out_valid || i_pop);
        last_sel    = (r_idx == i_head.nbytes - 1'b1);
        o_q_pop     = load && last_sel;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        if (load) begin
            n_idx       = last_sel ? '0 : r_idx + 1'b1;
            n_out_valid = 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= sel_byte;
            r_last     <= last_sel;
        end
    end

endmodule
